// ----- hw/rtl/mspc_pkg.sv -----
// Shared constants and types for the MIDI 8-to-7 bit pack codec.
package mspc_pkg;

	localparam int GROUP_BYTES = 7;
	localparam int IDX_W       = 3;
	localparam int BYTE_W      = 8;
	localparam int TOP_W       = GROUP_BYTES;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [IDX_W-1:0] GROUP_BYTES_C = IDX_W'(GROUP_BYTES);

	// register index, taken from paddr[2]
	localparam logic REG_DIRECTION = 1'b0;

	localparam logic DIR_PACK   = 1'b0;
	localparam logic DIR_UNPACK = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_FLUSH
	} mspc_state_t;

	typedef struct packed {
		logic take_in;
		logic emit_next;
	} mspc_cmd_t;

	typedef struct packed {
		logic out_free;
		logic group_done;
		logic final_byte;
	} mspc_stat_t;

endpackage

// ----- hw/rtl/midi_seven_bit_pack_codec_unit.sv -----
// Top level of the MIDI 8-to-7 bit pack codec: register port, controller and datapath.
// A result is in the output register in the cycle after the request that causes it.
// Unpack takes one request per cycle while the result register is free and gives at most one result for each.
// Pack takes one request per cycle while the result register is free; a request that closes a group of n
// bytes sends the header at once and blocks input while the result register sends the n bytes.
// Reset clears direction to pack and all message state; the group store is not cleared.
module midi_seven_bit_pack_codec_unit
	import mspc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BYTE_W-1:0]  in_byte,
	input  logic               end_of_message,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               last_result,
	output logic               bad_stream,
	output logic               empty_result
);

	mspc_cmd_t  cmd;
	mspc_stat_t stat;
	logic       dir_we;
	logic       direction;
	logic       reg_sel;

	assign reg_sel = paddr[PADDR_W-1];
	assign pready  = 1'b1;
	assign dir_we  = psel && penable && pwrite && (reg_sel == REG_DIRECTION);

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_DIRECTION: prdata = PDATA_W'(direction);
			default:       prdata = '0;
		endcase
	end

	mspc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mspc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dir_we         (dir_we),
		.dir_wdata      (pwdata[0]),
		.direction      (direction),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_result    (last_result),
		.bad_stream     (bad_stream),
		.empty_result   (empty_result)
	);

	// no input is taken while a group's bytes are going out
	a_no_take_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_next |-> !in_ready)
		else $error("input taken during group flush");

	// a request that closes a pack group loads its header right away
	a_header_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_in && stat.group_done |=> out_valid && !bad_stream && !empty_result)
		else $error("pack header missing after group close");

	// an error result carries no byte
	a_bad_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_stream |-> empty_result && (out_byte == '0))
		else $error("error result carries a byte");

	// packing never reports a stream error
	a_pack_no_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (direction == DIR_PACK) |-> !bad_stream)
		else $error("stream error in pack mode");

endmodule

// ----- hw/rtl/mspc_ctrl.sv -----
// Controller: accepts requests and sequences the data bytes of a packed group.
module mspc_ctrl
	import mspc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mspc_stat_t stat,
	output mspc_cmd_t  cmd
);

	mspc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.take_in   = 1'b0;
		cmd.emit_next = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = stat.out_free;
				cmd.take_in = in_valid && stat.out_free;
				// header goes out with the request; the bytes follow
				if (cmd.take_in && stat.group_done) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.emit_next = stat.out_free;
				if (cmd.emit_next && stat.final_byte) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/mspc_dp.sv -----
// Datapath: group store, message state, direction register and result register.
module mspc_dp
	import mspc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dir_we,
	input  logic              dir_wdata,
	output logic              direction,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              end_of_message,
	input  mspc_cmd_t         cmd,
	output mspc_stat_t        stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_result,
	output logic              bad_stream,
	output logic              empty_result
);

	logic [BYTE_W-1:0] store_q [GROUP_BYTES];

	logic              direction_q;
	logic [IDX_W-1:0]  group_count_q;
	logic [TOP_W-1:0]  top_bits_q;
	logic              expect_header_q;
	logic              dropping_q;
	logic [IDX_W-1:0]  emit_idx_q;
	logic [IDX_W-1:0]  emit_cnt_q;
	logic              emit_eom_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              bad_q;
	logic              empty_q;

	logic [IDX_W-1:0]  idx_c;
	logic [IDX_W-1:0]  idx_inc_c;
	logic              grp_full_c;
	logic [TOP_W-1:0]  top_new_c;
	logic              pack_done_c;
	logic              pack_in_c;
	logic              load_in_c;

	logic              up_res_c;
	logic [BYTE_W-1:0] up_byte_c;
	logic              up_last_c;
	logic              up_bad_c;
	logic              up_empty_c;

	assign idx_c       = (group_count_q >= GROUP_BYTES_C) ? '0 : group_count_q;
	assign idx_inc_c   = idx_c + 1'b1;
	assign grp_full_c  = (idx_inc_c >= GROUP_BYTES_C);
	assign top_new_c   = top_bits_q | (TOP_W'(in_byte[BYTE_W-1]) << idx_c);
	assign pack_done_c = grp_full_c || end_of_message;
	assign pack_in_c   = cmd.take_in && (direction_q == DIR_PACK);

	assign stat.out_free   = !out_valid_q || out_ready;
	assign stat.group_done = (direction_q == DIR_PACK) && pack_done_c;
	assign stat.final_byte = (IDX_W'(emit_idx_q + 1'b1) == emit_cnt_q);

	// unpack gives at most one result per request
	always_comb begin
		up_res_c   = 1'b0;
		up_byte_c  = '0;
		up_last_c  = 1'b0;
		up_bad_c   = 1'b0;
		up_empty_c = 1'b0;
		if (dropping_q) begin
			if (end_of_message) begin
				up_res_c   = 1'b1;
				up_last_c  = 1'b1;
				up_empty_c = 1'b1;
			end
		end else if (in_byte[BYTE_W-1]) begin
			up_res_c   = 1'b1;
			up_last_c  = end_of_message;
			up_bad_c   = 1'b1;
			up_empty_c = 1'b1;
		end else if (expect_header_q) begin
			if (end_of_message) begin
				up_res_c   = 1'b1;
				up_last_c  = 1'b1;
				up_empty_c = 1'b1;
			end
		end else begin
			up_res_c  = 1'b1;
			up_byte_c = {top_bits_q[idx_c], in_byte[BYTE_W-2:0]};
			up_last_c = end_of_message;
		end
	end

	assign load_in_c = cmd.take_in && (pack_in_c ? pack_done_c : up_res_c);

	always_ff @(posedge clk) begin
		if (pack_in_c) begin
			store_q[idx_c] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q     <= DIR_PACK;
			group_count_q   <= '0;
			top_bits_q      <= '0;
			expect_header_q <= 1'b1;
			dropping_q      <= 1'b0;
		end else if (dir_we) begin
			direction_q     <= dir_wdata;
			group_count_q   <= '0;
			top_bits_q      <= '0;
			expect_header_q <= 1'b1;
			dropping_q      <= 1'b0;
		end else if (cmd.take_in) begin
			if (direction_q == DIR_PACK) begin
				if (pack_done_c) begin
					group_count_q <= '0;
					top_bits_q    <= '0;
				end else begin
					group_count_q <= idx_inc_c;
					top_bits_q    <= top_new_c;
				end
			end else if (dropping_q) begin
				// nothing until end of message
			end else if (in_byte[BYTE_W-1]) begin
				dropping_q <= 1'b1;
			end else if (expect_header_q) begin
				top_bits_q      <= in_byte[TOP_W-1:0];
				expect_header_q <= 1'b0;
				group_count_q   <= '0;
			end else begin
				group_count_q   <= grp_full_c ? '0 : idx_inc_c;
				expect_header_q <= grp_full_c;
			end
			if (end_of_message) begin
				group_count_q   <= '0;
				top_bits_q      <= '0;
				expect_header_q <= 1'b1;
				dropping_q      <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
			emit_cnt_q <= '0;
			emit_eom_q <= 1'b0;
		end else if (pack_in_c && pack_done_c) begin
			emit_idx_q <= '0;
			emit_cnt_q <= idx_inc_c;
			emit_eom_q <= end_of_message;
		end else if (cmd.emit_next) begin
			emit_idx_q <= emit_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_in_c || cmd.emit_next) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_next) begin
			out_byte_q <= {1'b0, store_q[emit_idx_q][BYTE_W-2:0]};
			last_q     <= emit_eom_q && stat.final_byte;
			bad_q      <= 1'b0;
			empty_q    <= 1'b0;
		end else if (load_in_c) begin
			if (pack_in_c) begin
				// group header: bit b is bit 7 of byte b
				out_byte_q <= BYTE_W'(top_new_c);
				last_q     <= 1'b0;
				bad_q      <= 1'b0;
				empty_q    <= 1'b0;
			end else begin
				out_byte_q <= up_byte_c;
				last_q     <= up_last_c;
				bad_q      <= up_bad_c;
				empty_q    <= up_empty_c;
			end
		end
	end

	assign direction    = direction_q;
	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_result  = last_q;
	assign bad_stream   = bad_q;
	assign empty_result = empty_q;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the MIDI 8-to-7 bit pack/unpack codec.
module tb_top;
	import mspc_pkg::*;

	localparam int WATCHDOG_LIMIT = 500;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 4;
	localparam int RANDOM_ITEMS   = 180;
	localparam int PHASES         = 8;
	localparam logic [PADDR_W-1:0] DIR_ADDR = {REG_DIRECTION, 2'b00};

	typedef struct packed {
		logic [BYTE_W-1:0] dat;
		logic              is_last;
		logic              is_bad;
		logic              is_empty;
	} codec_res_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [BYTE_W-1:0]  in_byte;
	logic               end_of_message;
	logic               out_valid;
	logic               out_ready;
	logic [BYTE_W-1:0]  out_byte;
	logic               last_result;
	logic               bad_stream;
	logic               empty_result;

	midi_seven_bit_pack_codec_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.last_result    (last_result),
		.bad_stream     (bad_stream),
		.empty_result   (empty_result)
	);

	// codec mirror state
	logic [BYTE_W-1:0] grp_store [GROUP_BYTES];
	logic [IDX_W-1:0]  grp_cnt;
	logic [TOP_W-1:0]  hdr_bits;
	logic              want_hdr;
	logic              drop_msg;
	logic              dir_m;

	codec_res_t        pending_res [$];
	codec_res_t        head_res;
	codec_res_t        seen_res;
	logic [BYTE_W-1:0] msg_q [$];

	int  mismatches;
	int  reqs_taken;
	int  reqs_ignored;
	int  results_seen;
	int  dir_writes;
	int  idle_cycles;
	int  burst_left;
	bit  idle_on;
	bit  last_ignored;
	int  rx_mode;
	int  rx_cyc;
	int  rx_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic note_mismatch(input string what, input codec_res_t want,
		input codec_res_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("MISMATCH %s: exp byte=%02h last=%b bad=%b empty=%b",
				what, want.dat, want.is_last, want.is_bad, want.is_empty);
			$display("    got byte=%02h last=%b bad=%b empty=%b",
				got.dat, got.is_last, got.is_bad, got.is_empty);
		end
	endtask

	task automatic clear_msg();
		grp_cnt  = '0;
		hdr_bits = '0;
		want_hdr = 1'b1;
		drop_msg = 1'b0;
	endtask

	task automatic push_res(input logic [BYTE_W-1:0] d, input logic l, input logic b,
		input logic e);
		codec_res_t r;
		r.dat      = d;
		r.is_last  = l;
		r.is_bad   = b;
		r.is_empty = e;
		pending_res.push_back(r);
	endtask

	// work out the results of one accepted request
	task automatic codec_predict(input logic [BYTE_W-1:0] din, input logic eom);
		int idx;
		last_ignored = 1'b0;
		if (dir_m == DIR_PACK) begin
			idx = grp_cnt;
			if (idx >= GROUP_BYTES)
				idx = 0;
			grp_store[idx] = din;
			if (din[7])
				hdr_bits[idx] = 1'b1;
			idx++;
			if (idx < GROUP_BYTES && !eom) begin
				grp_cnt = IDX_W'(idx);
			end else begin
				push_res({1'b0, hdr_bits}, 1'b0, 1'b0, 1'b0);
				for (int k = 0; k < idx; k++)
					push_res({1'b0, grp_store[k][6:0]}, eom && (k + 1 == idx), 1'b0, 1'b0);
				grp_cnt  = '0;
				hdr_bits = '0;
				if (eom)
					clear_msg();
			end
		end else if (drop_msg) begin
			if (eom) begin
				push_res('0, 1'b1, 1'b0, 1'b1);
				clear_msg();
			end else begin
				last_ignored = 1'b1;
			end
		end else if (din[7]) begin
			push_res('0, eom, 1'b1, 1'b1);
			if (eom)
				clear_msg();
			else
				drop_msg = 1'b1;
		end else if (want_hdr) begin
			hdr_bits = din[6:0];
			want_hdr = 1'b0;
			grp_cnt  = '0;
			if (eom) begin
				push_res('0, 1'b1, 1'b0, 1'b1);
				clear_msg();
			end
		end else begin
			idx = grp_cnt;
			if (idx >= GROUP_BYTES)
				idx = 0;
			push_res({hdr_bits[idx], din[6:0]}, eom, 1'b0, 1'b0);
			idx++;
			if (idx >= GROUP_BYTES) begin
				grp_cnt  = '0;
				want_hdr = 1'b1;
			end else begin
				grp_cnt = IDX_W'(idx);
			end
			if (eom)
				clear_msg();
		end
	endtask

	// one request; the sender may idle between bursts
	task automatic send_item(input logic [BYTE_W-1:0] b, input logic eom);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = idle_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid       <= 1'b1;
		in_byte        <= b;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		codec_predict(b, eom);
		if (last_ignored)
			reqs_ignored++;
		else
			reqs_taken++;
	endtask

	task automatic send_msg_q(input bit with_eom);
		int n;
		n = msg_q.size();
		for (int i = 0; i < n; i++)
			send_item(msg_q[i], with_eom && (i == n - 1));
		msg_q.delete();
	endtask

	// stop sending and let every outstanding result come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] a, output logic [PDATA_W-1:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		d = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_direction();
		logic [PDATA_W-1:0] rd;
		apb_read(DIR_ADDR, rd);
		if (rd !== PDATA_W'(dir_m)) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH direction read: exp %0h got %0h", dir_m, rd);
		end
	endtask

	// a direction write also throws away any half-built group
	task automatic set_direction(input logic d);
		drain();
		apb_write(DIR_ADDR, PDATA_W'(d));
		dir_m = d;
		clear_msg();
		dir_writes++;
		check_direction();
	endtask

	task automatic test_reset_value();
		check_direction();
	endtask

	task automatic test_pack_directed();
		logic [BYTE_W-1:0] grp [7] = '{8'hFF, 8'h80, 8'h00, 8'h7F, 8'h01, 8'hAA, 8'h55};
		set_direction(DIR_PACK);
		// full group that also ends the message
		for (int i = 0; i < 7; i++)
			send_item(grp[i], i == 6);
		send_item(8'h80, 1'b1);
		// partial group dropped by the direction change below
		send_item(8'h81, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(8'hFE, 1'b0);
	endtask

	task automatic test_unpack_directed();
		logic [BYTE_W-1:0] grp [7] = '{8'h00, 8'h7F, 8'h00, 8'h7F, 8'h55, 8'h2A, 8'h7F};
		set_direction(DIR_UNPACK);
		// full group, then a second header with one byte
		send_item(8'h7F, 1'b0);
		for (int i = 0; i < 7; i++)
			send_item(grp[i], 1'b0);
		send_item(8'h01, 1'b0);
		send_item(8'h7F, 1'b1);
		// header that ends the message
		send_item(8'h05, 1'b1);
		// bad header, rest of message dropped
		send_item(8'hFF, 1'b0);
		send_item(8'h12, 1'b0);
		send_item(8'h00, 1'b1);
		// bad data byte on the final request
		send_item(8'h00, 1'b0);
		send_item(8'h80, 1'b1);
	endtask

	function automatic logic [BYTE_W-1:0] rand_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return BYTE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic build_pack_msg();
		int len;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 15);
		for (int i = 0; i < len; i++)
			msg_q.push_back(rand_byte());
	endtask

	task automatic build_unpack_msg();
		int groups;
		int n;
		int pos;
		if ($urandom_range(0, 99) < 15) begin
			// noise
			n = $urandom_range(1, 10);
			for (int i = 0; i < n; i++)
				msg_q.push_back(rand_byte());
		end else begin
			groups = $urandom_range(1, 3);
			for (int g = 0; g < groups; g++) begin
				msg_q.push_back(BYTE_W'($urandom_range(0, 127)));
				n = (g < groups - 1) ? GROUP_BYTES : $urandom_range(0, GROUP_BYTES);
				for (int i = 0; i < n; i++)
					msg_q.push_back(BYTE_W'($urandom_range(0, 127)));
			end
			if ($urandom_range(0, 99) < 12) begin
				pos = $urandom_range(0, msg_q.size() - 1);
				msg_q[pos] = msg_q[pos] | 8'h80;
			end
		end
	endtask

	task automatic test_random_mix();
		int goal;
		logic d;
		for (int ph = 0; ph < PHASES; ph++) begin
			d = (ph < 2) ? logic'(ph) : logic'($urandom_range(0, 1));
			set_direction(d);
			idle_on = (ph != 3);
			goal = reqs_taken + RANDOM_ITEMS / PHASES;
			while (reqs_taken < goal) begin
				if (d == DIR_PACK)
					build_pack_msg();
				else
					build_unpack_msg();
				send_msg_q(1'b1);
			end
			// sometimes leave a message open across the direction change
			if ($urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(1, 5)) begin
					if (d == DIR_PACK)
						msg_q.push_back(rand_byte());
					else
						msg_q.push_back(BYTE_W'($urandom_range(0, 127)));
				end
				send_msg_q(1'b0);
			end
		end
		set_direction(DIR_PACK);
	endtask

	// receiver backpressure
	initial begin
		out_ready = 1'b0;
		rx_mode   = 0;
		rx_cyc    = 0;
		rx_hold   = 0;
		forever begin
			@(negedge clk);
			rx_cyc++;
			if (rx_cyc % 128 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (rx_cyc % 9) >= 4;
				default: begin
					if (rx_hold > 0) begin
						rx_hold--;
						out_ready <= 1'b0;
					end else begin
						if ($urandom_range(0, 7) == 0)
							rx_hold = $urandom_range(1, 10);
						out_ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			seen_res = '{dat: out_byte, is_last: last_result, is_bad: bad_stream,
				is_empty: empty_result};
			if (pending_res.size() == 0) begin
				note_mismatch("unexpected result", '0, seen_res);
			end else begin
				head_res = pending_res.pop_front();
				if (seen_res !== head_res)
					note_mismatch("result", head_res, seen_res);
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		in_valid       = 1'b0;
		in_byte        = '0;
		end_of_message = 1'b0;
		mismatches     = 0;
		reqs_taken     = 0;
		reqs_ignored   = 0;
		results_seen   = 0;
		dir_writes     = 0;
		burst_left     = 0;
		idle_on        = 1'b1;
		dir_m          = DIR_PACK;
		clear_msg();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_value();
		test_pack_directed();
		test_unpack_directed();
		test_random_mix();

		drain();
		if (pending_res.size() != 0) begin
			mismatches++;
			$display("%0d expected results never arrived", pending_res.size());
		end
		$display("Covered %0d requests (%0d dropped) and %0d results in pack and unpack",
			reqs_taken, reqs_ignored, results_seen);
		$display("with %0d direction writes and %0d mismatches", dir_writes, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
